[rtl/krt_pkg.sv]
// Shared types and constants of the keyed retention table.
// Depends on nothing; keyed_retention_table and krt_engine import it.
package krt_pkg;

    // Table geometry.
    localparam int TABLE_SLOTS = 16;
    localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int SCAN_W      = $clog2(TABLE_SLOTS + 1);

    // Field widths.
    localparam int CMD_W      = 2;
    localparam int KIND_W     = 2;
    localparam int ID_W       = 32;
    localparam int HANDLE_W   = 64;
    localparam int STATUS_W   = 4;
    localparam int COUNT_W    = 7;
    localparam int CAP_W      = 6;
    localparam int CFG_ADDR_W = 1;

    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
    localparam logic [CAP_W-1:0]  CAP_RESET    = 6'd16;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_CAPACITY = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SEALED   = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_RETAIN  = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_CLEAR   = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 4'd0,
        STS_DUPLICATE = 4'd1,
        STS_BAD_KEY   = 4'd2,
        STS_NULL      = 4'd3,
        STS_FULL      = 4'd4,
        STS_CONFLICT  = 4'd5,
        STS_SEALED    = 4'd6,
        STS_BAD_CAP   = 4'd7,
        STS_NOT_FOUND = 4'd8
    } t_status;

    typedef struct packed {
        t_cmd                cmd;
        logic [KIND_W-1:0]   kind;
        logic [ID_W-1:0]     resource_id;
        logic [ID_W-1:0]     owner_id;
        logic [HANDLE_W-1:0] handle;
    } t_item;

    // One stored entry: key and handle.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [ID_W-1:0]     owner_id;
        logic [ID_W-1:0]     resource_id;
        logic [KIND_W-1:0]   kind;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [CAP_W-1:0] capacity;
        logic             sealed;
    } t_cfg;

    typedef struct packed {
        t_status              status;
        logic [COUNT_W-1:0]   entry_count;
    } t_result;

endpackage

[rtl/keyed_retention_table.sv]
// Keyed retention table: retain, release and clear of keyed handle entries.
// A command settled by the capacity, key or handle checks passes through the engine states
// EVAL and RESULT and then the output register; a scan of the entry RAM, one slot read per
// cycle, adds a SCAN state between EVAL and RESULT. The input is free again in IDLE.
// Reset (synchronous, active low) empties every slot, zeroes the count and sets
// capacity to 16 and sealed to 0. Depends on krt_pkg and krt_engine.
module keyed_retention_table
    import krt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CAP_W-1:0]      i_cfg_wdata,
    // Command beats.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: kind[1:0], resource_id[33:2], owner_id[65:34], handle[129:66], zero fill.
    input  logic [135:0]          s_axis_tdata,
    // tuser: cmd[1:0].
    input  logic [CMD_W-1:0]      s_axis_tuser,
    // Result beats.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: status[3:0], entry_count[10:4], zero fill.
    output logic [15:0]           m_axis_tdata
);

    t_cfg    r_cfg;
    t_item   in_item;
    t_result res;
    logic    res_valid;
    logic    res_ready;
    t_result r_out;
    logic    r_out_vld;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity <= CAP_RESET;
            r_cfg.sealed   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_CAPACITY: r_cfg.capacity <= i_cfg_wdata;
                REG_SEALED:   r_cfg.sealed   <= i_cfg_wdata[0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    // Unpack the command beat.
    assign in_item = '{cmd:         t_cmd'(s_axis_tuser),
                       kind:        s_axis_tdata[1:0],
                       resource_id: s_axis_tdata[33:2],
                       owner_id:    s_axis_tdata[65:34],
                       handle:      s_axis_tdata[129:66]};

    krt_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_item      (in_item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_result    (res)
    );

    // Output register: takes a new result while it is empty or being drained downstream.
    assign res_ready = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'd0, r_out.entry_count, r_out.status};

endmodule

[rtl/krt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module krt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/krt_engine.sv]
// Command sequencer of the keyed retention table: slot occupancy bits, entry
// count, and a scan over the entry RAM. Depends on krt_pkg and krt_ram.
module krt_engine
    import krt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_item   i_item,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_result
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EVAL   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_RESULT = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    t_item               r_item;
    logic [SCAN_W-1:0]   r_lim, n_lim;
    logic [SCAN_W-1:0]   r_scan_idx, n_scan_idx;
    logic                r_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic                r_free_vld, n_free_vld;
    logic [IDX_W-1:0]    r_free_idx, n_free_idx;
    t_status             r_status, n_status;
    logic                r_wr_en, n_wr_en;
    logic                r_rel_en, n_rel_en;
    logic                r_clr, n_clr;
    logic [IDX_W-1:0]    r_wr_idx, n_wr_idx;
    logic [TABLE_SLOTS-1:0] r_used, n_used;
    logic [COUNT_W-1:0]  r_count, n_count;

    logic                cap_ok;
    logic                key_bad;
    logic                issue;
    logic                used_c;
    logic                hit;
    logic                finish_miss;
    logic                ram_we;
    logic [ENTRY_W-1:0]  ram_rdata;
    t_entry              rd_entry;
    t_entry              wr_entry;

    assign rd_entry = t_entry'(ram_rdata);

    // Entry storage: one word per slot.
    assign wr_entry = '{handle:      r_item.handle,
                        owner_id:    r_item.owner_id,
                        resource_id: r_item.resource_id,
                        kind:        r_item.kind};

    krt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_idx),
        .i_wdata (wr_entry),
        .i_re    (issue),
        .i_raddr (r_scan_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Capacity setting and key checks on the held command.
    assign cap_ok  = (i_cfg.capacity != '0) && (int'(i_cfg.capacity) <= TABLE_SLOTS);
    assign key_bad = (r_item.kind == KIND_UNKNOWN) || (r_item.resource_id == '0) ||
                     (r_item.owner_id == '0);

    // Scan: one read issued per cycle, compared in the cycle after.
    assign issue  = (r_state == ST_SCAN) && (r_scan_idx < r_lim);
    assign used_c = r_used[r_cmp_idx];
    assign hit    = r_cmp_vld && used_c && (rd_entry.kind == r_item.kind) &&
                    (rd_entry.resource_id == r_item.resource_id) &&
                    (rd_entry.owner_id == r_item.owner_id);
    assign finish_miss = !issue && !hit;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_RESULT);
    assign ram_we      = (r_state == ST_RESULT) && i_res_ready && r_wr_en;

    // Next-state and decision logic.
    always_comb begin
        n_state    = r_state;
        n_lim      = r_lim;
        n_scan_idx = r_scan_idx;
        n_free_vld = r_free_vld;
        n_free_idx = r_free_idx;
        n_status   = r_status;
        n_wr_en    = r_wr_en;
        n_rel_en   = r_rel_en;
        n_clr      = r_clr;
        n_wr_idx   = r_wr_idx;
        n_used     = r_used;
        n_count    = r_count;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state  = ST_EVAL;
                    n_wr_en  = 1'b0;
                    n_rel_en = 1'b0;
                    n_clr    = 1'b0;
                end
            end
            ST_EVAL: begin
                n_lim      = cap_ok ? SCAN_W'(i_cfg.capacity) : '0;
                n_scan_idx = '0;
                n_free_vld = 1'b0;
                n_status   = STS_OK;
                n_state    = ST_RESULT;
                unique case (r_item.cmd)
                    CMD_RETAIN: begin
                        if (!cap_ok) begin
                            n_status = STS_BAD_CAP;
                        end else if (key_bad) begin
                            n_status = STS_BAD_KEY;
                        end else if (r_item.handle == '0) begin
                            n_status = STS_NULL;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end
                    CMD_RELEASE: begin
                        if (!cap_ok) begin
                            n_status = STS_NOT_FOUND;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end
                    CMD_CLEAR: begin
                        n_clr = 1'b1;
                    end
                    default: begin
                        n_status = STS_OK;
                    end
                endcase
            end
            ST_SCAN: begin
                if (issue) begin
                    n_scan_idx = r_scan_idx + SCAN_W'(1);
                end
                // The lowest empty slot seen so far.
                if (r_cmp_vld && !used_c && !r_free_vld) begin
                    n_free_vld = 1'b1;
                    n_free_idx = r_cmp_idx;
                end
                if (hit) begin
                    n_state = ST_RESULT;
                    if (r_item.cmd == CMD_RETAIN) begin
                        n_status = (rd_entry.handle == r_item.handle) ? STS_DUPLICATE
                                                                      : STS_CONFLICT;
                    end else begin
                        n_status = STS_OK;
                        n_rel_en = 1'b1;
                        n_wr_idx = r_cmp_idx;
                    end
                end else if (finish_miss) begin
                    n_state = ST_RESULT;
                    if (r_item.cmd == CMD_RETAIN) begin
                        if (i_cfg.sealed) begin
                            n_status = STS_SEALED;
                        end else if (n_free_vld) begin
                            n_status = STS_OK;
                            n_wr_en  = 1'b1;
                            n_wr_idx = n_free_idx;
                        end else begin
                            n_status = STS_FULL;
                        end
                    end else begin
                        n_status = STS_NOT_FOUND;
                    end
                end
            end
            ST_RESULT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
                // Occupancy and count after this command.
                if (r_clr) begin
                    n_used  = '0;
                    n_count = '0;
                end else if (r_wr_en) begin
                    n_used[r_wr_idx] = 1'b1;
                    n_count          = r_count + COUNT_W'(1);
                end else if (r_rel_en) begin
                    n_used[r_wr_idx] = 1'b0;
                    n_count          = (r_count != '0) ? r_count - COUNT_W'(1) : r_count;
                end
                if (!i_res_ready) begin
                    n_used  = r_used;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_result = '{status: r_status, entry_count: n_count};

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_used     <= '0;
            r_count    <= '0;
            r_cmp_vld  <= 1'b0;
            r_free_vld <= 1'b0;
            r_wr_en    <= 1'b0;
            r_rel_en   <= 1'b0;
            r_clr      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_free_vld <= n_free_vld;
            r_wr_en    <= n_wr_en;
            r_rel_en   <= n_rel_en;
            r_clr      <= n_clr;
            r_cmp_vld  <= issue;
            if ((r_state == ST_RESULT) && i_res_ready) begin
                r_count <= n_count;
            end
        end
    end

    // Held command and scan bookkeeping.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= i_item;
        end
        r_lim      <= n_lim;
        r_scan_idx <= n_scan_idx;
        r_cmp_idx  <= r_scan_idx[IDX_W-1:0];
        r_free_idx <= n_free_idx;
        r_status   <= n_status;
        r_wr_idx   <= n_wr_idx;
    end

    // The count always equals the number of occupied slots.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == COUNT_W'($countones(r_used)))
        else $error("entry count differs from occupied slots");

    // The scan pointer never runs past the effective capacity.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_scan_idx <= r_lim))
        else $error("scan pointer beyond capacity");

    // A new entry only goes into an empty slot.
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !r_used[r_wr_idx])
        else $error("retain overwrote an occupied slot");

    // A delivered clear leaves the table empty.
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RESULT) && i_res_ready && r_clr) |=> (r_used == '0))
        else $error("clear left occupied slots");

endmodule
